FILE: rtl/siphb_pkg.sv
// Shared types, constants and the SipRound function for the SipHash-2-4 byte stream block.
// No dependencies; imported by siphash24_byte_stream.
package siphb_pkg;

    localparam logic [63:0] IV0 = 64'h736f6d6570736575;
    localparam logic [63:0] IV1 = 64'h646f72616e646f6d;
    localparam logic [63:0] IV2 = 64'h6c7967656e657261;
    localparam logic [63:0] IV3 = 64'h7465646279746573;

    localparam logic [63:0] FINAL_XOR      = 64'h00000000000000ff;
    localparam logic [3:0]  BYTES_PER_WORD = 4'd8;
    localparam logic [31:0] LIMIT_RESET    = 32'hffffffff;

    typedef logic [3:0][63:0] t_lanes;

    typedef enum logic {
        CFG_HASH_KEY   = 1'b0,
        CFG_BYTE_LIMIT = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PACK,
        S_ROUND,
        S_TAIL,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        PH_BLOCK,
        PH_TAIL,
        PH_FINAL
    } t_phase;

    function automatic t_lanes key_lanes(input logic [63:0] key);
        t_lanes v;
        v[0] = IV0 ^ key;
        v[1] = IV1 ^ key;
        v[2] = IV2 ^ key;
        v[3] = IV3 ^ key;
        return v;
    endfunction

    // Low n bytes set, n in 0..8
    function automatic logic [63:0] byte_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < n) begin
                m[8*i +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

    function automatic t_lanes sip_round(input t_lanes v);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
        t_lanes      r;
        a = v[0];
        b = v[1];
        c = v[2];
        d = v[3];
        a = a + b;
        b = {b[50:0], b[63:51]};
        b = b ^ a;
        a = {a[31:0], a[63:32]};
        c = c + d;
        d = {d[47:0], d[63:48]};
        d = d ^ c;
        a = a + d;
        d = {d[42:0], d[63:43]};
        d = d ^ a;
        c = c + b;
        b = {b[46:0], b[63:47]};
        b = b ^ c;
        c = {c[31:0], c[63:32]};
        r[0] = a;
        r[1] = b;
        r[2] = c;
        r[3] = d;
        return r;
    endfunction

endpackage

FILE: rtl/siphash24_byte_stream.sv
// SipHash-2-4 over a byte stream of 64-bit little-endian words, one shared round unit.
// Depends on siphb_pkg (types, IVs, sip_round, byte_mask).
//
// Usage: configuration writes (index 0 key, index 1 byte limit) go over the cfg channel while
// the block is idle; a key write restarts the message. Message words enter on the msg channel
// with a byte count (0..8, above 8 read as 8) and a last flag; bytes pack contiguously across
// words and bytes at or beyond the byte limit are dropped.
// Timing: one SipRound per cycle on a single round unit. A word that does not complete an
// 8-byte block is packed and the block returns to idle, ready for the next item; one that
// completes a block runs its COMPRESSION_ROUNDS rounds after packing. On a last word the hash
// appears on o_hash_value after packing, the tail block, its rounds, finalisation and the
// output load, with the block rounds first if the word also completes a block; the next
// item can be taken as soon as the hash is loaded.
// The hash sits in an output register: the next message can be accepted while it waits. If
// the receiver stalls and a further hash is finished, the block holds in its done state with
// msg ready low until the old hash is taken.
// Reset: key 0, byte limit all ones, lanes loaded from the key, no hash pending.
module siphash24_byte_stream
    import siphb_pkg::*;
#(
    parameter int COMPRESSION_ROUNDS = 2,
    parameter int FINAL_ROUNDS       = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_msg_valid,
    output logic        o_msg_ready,
    input  logic [63:0] i_message_word,
    input  logic [3:0]  i_valid_bytes,
    input  logic        i_last_word,
    output logic        o_hash_valid,
    input  logic        i_hash_ready,
    output logic [63:0] o_hash_value
);

    localparam int MAX_ROUNDS = (COMPRESSION_ROUNDS > FINAL_ROUNDS) ?
                                COMPRESSION_ROUNDS : FINAL_ROUNDS;
    localparam int RW = $clog2(MAX_ROUNDS + 1);

    t_state      r_state, n_state;
    t_phase      r_phase, n_phase;
    logic [RW-1:0] r_rnd, n_rnd;
    t_lanes      r_lanes, n_lanes;
    logic [63:0] r_m, n_m;
    logic [31:0] r_total, n_total;
    logic [63:0] r_tail, n_tail;
    logic [63:0] r_key, n_key;
    logic [31:0] r_limit, n_limit;
    logic [63:0] r_word, n_word;
    logic [3:0]  r_cnt, n_cnt;
    logic        r_last, n_last;
    logic [63:0] r_hash, n_hash;
    logic        r_out_valid, n_out_valid;

    logic        w_msg_acc;
    logic        w_cfg_acc;
    logic        w_out_free;
    logic [31:0] w_room;
    logic [3:0]  w_take;
    logic [2:0]  w_pos;
    logic [63:0] w_wm;
    logic [63:0] w_low;
    logic [63:0] w_high;
    logic        w_full;
    logic        w_rnd_done;
    logic [63:0] w_tail_blk;
    t_lanes      w_round;

    assign w_msg_acc  = i_msg_valid && o_msg_ready;
    assign w_cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign w_out_free = !r_out_valid || i_hash_ready;

    // Bytes still allowed under the limit, and how many of this word to keep
    assign w_room = (r_total < r_limit) ? (r_limit - r_total) : 32'd0;
    assign w_take = (w_room < 32'(r_cnt)) ? w_room[3:0] : r_cnt;
    assign w_pos  = r_total[2:0];
    assign w_wm   = r_word & byte_mask(w_take);
    assign w_low  = r_tail | (w_wm << {w_pos, 3'b000});
    assign w_high = (w_pos == 3'd0) ? 64'd0 : (w_wm >> (7'd64 - {1'b0, w_pos, 3'b000}));
    assign w_full = ({1'b0, w_pos} + w_take) >= BYTES_PER_WORD;

    assign w_tail_blk = r_tail | {r_total[7:0], 56'd0};
    assign w_round    = sip_round(r_lanes);
    assign w_rnd_done = (r_phase == PH_FINAL) ? (r_rnd == RW'(FINAL_ROUNDS - 1))
                                              : (r_rnd == RW'(COMPRESSION_ROUNDS - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_msg_acc) begin
                    n_state = S_PACK;
                end
            end
            S_PACK: begin
                if (w_full) begin
                    n_state = S_ROUND;
                end else if (r_last) begin
                    n_state = S_TAIL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ROUND: begin
                if (w_rnd_done) begin
                    unique case (r_phase)
                        PH_BLOCK: n_state = r_last ? S_TAIL : S_IDLE;
                        PH_TAIL:  n_state = S_ROUND;
                        PH_FINAL: n_state = S_DONE;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_TAIL: begin
                n_state = S_ROUND;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        o_msg_ready  = (r_state == S_IDLE);
        o_cfg_ready  = (r_state == S_IDLE);
        o_hash_valid = r_out_valid;
        o_hash_value = r_hash;
    end

    // Datapath
    always_comb begin
        n_phase     = r_phase;
        n_rnd       = r_rnd;
        n_lanes     = r_lanes;
        n_m         = r_m;
        n_total     = r_total;
        n_tail      = r_tail;
        n_key       = r_key;
        n_limit     = r_limit;
        n_word      = r_word;
        n_cnt       = r_cnt;
        n_last      = r_last;
        n_hash      = r_hash;
        n_out_valid = r_out_valid && !i_hash_ready;

        case (r_state)
            S_IDLE: begin
                if (w_cfg_acc) begin
                    unique case (t_cfg_idx'(i_cfg_index))
                        CFG_HASH_KEY: begin
                            n_key   = i_cfg_data;
                            n_lanes = key_lanes(i_cfg_data);
                            n_total = '0;
                            n_tail  = '0;
                        end
                        CFG_BYTE_LIMIT: begin
                            n_limit = i_cfg_data[31:0];
                        end
                        default: ;
                    endcase
                end
                if (w_msg_acc) begin
                    n_word = i_message_word;
                    n_cnt  = (i_valid_bytes > BYTES_PER_WORD) ? BYTES_PER_WORD : i_valid_bytes;
                    n_last = i_last_word;
                end
            end
            S_PACK: begin
                n_total = r_total + 32'(w_take);
                if (w_full) begin
                    n_lanes[3] = r_lanes[3] ^ w_low;
                    n_m        = w_low;
                    n_tail     = w_high;
                    n_phase    = PH_BLOCK;
                    n_rnd      = '0;
                end else begin
                    n_tail = w_low;
                end
            end
            S_TAIL: begin
                n_lanes[3] = r_lanes[3] ^ w_tail_blk;
                n_m        = w_tail_blk;
                n_phase    = PH_TAIL;
                n_rnd      = '0;
            end
            S_ROUND: begin
                n_lanes = w_round;
                n_rnd   = r_rnd + RW'(1);
                if (w_rnd_done) begin
                    n_rnd = '0;
                    case (r_phase)
                        PH_BLOCK: begin
                            n_lanes[0] = w_round[0] ^ r_m;
                        end
                        PH_TAIL: begin
                            n_lanes[0] = w_round[0] ^ r_m;
                            n_lanes[2] = w_round[2] ^ FINAL_XOR;
                            n_phase    = PH_FINAL;
                        end
                        default: ;
                    endcase
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_hash      = r_lanes[0] ^ r_lanes[1] ^ r_lanes[2] ^ r_lanes[3];
                    n_out_valid = 1'b1;
                    n_lanes     = key_lanes(r_key);
                    n_total     = '0;
                    n_tail      = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_BLOCK;
            r_rnd       <= '0;
            r_lanes     <= key_lanes(64'd0);
            r_total     <= '0;
            r_tail      <= '0;
            r_key       <= '0;
            r_limit     <= LIMIT_RESET;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_rnd       <= n_rnd;
            r_lanes     <= n_lanes;
            r_total     <= n_total;
            r_tail      <= n_tail;
            r_key       <= n_key;
            r_limit     <= n_limit;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        r_m    <= n_m;
        r_word <= n_word;
        r_cnt  <= n_cnt;
        r_hash <= n_hash;
    end

`ifndef SYNTHESIS
    a_accept_to_pack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_msg_acc |=> (r_state == S_PACK) && (r_cnt <= BYTES_PER_WORD))
        else $error("accepted item did not reach packing with a clamped count");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && w_out_free |=>
            o_hash_valid && (r_total == 32'd0) && (r_tail == 64'd0) && (r_state == S_IDLE))
        else $error("hash load did not restart the message");

    a_tail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_tail & ~byte_mask({1'b0, w_pos})) == 64'd0))
        else $error("tail holds bytes beyond the packing position");

    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (32'(r_rnd) < 32'(MAX_ROUNDS)))
        else $error("round counter overran");
`endif

endmodule
